[src/vad_pkg.sv]
// shared types, constants and the cosine-squared table for the vector angle block
package vad_pkg;

    // component width of the input vectors
    localparam int CoordBits = 16;
    // width of squared lengths and of the dot product magnitude
    localparam int ProdBits  = 2 * CoordBits;
    // width of |a|^2*|b|^2 and of dot^2
    localparam int WideBits  = 2 * ProdBits;
    // quotient dot^2 * 2^60 / (|a|^2*|b|^2) lies in 0..2^60
    localparam int QBits     = 61;
    // one binary-search step per bit of the degree count
    localparam int SrchSteps = 7;
    localparam int TabDepth  = 90;
    // degrees that the search may count above the base angle
    localparam logic [SrchSteps-1:0] CountPos = 7'd89;
    localparam logic [SrchSteps-1:0] CountNeg = 7'd90;
    localparam logic [7:0] AngleRight = 8'd90;
    localparam logic [63:0] PiQ30 = 64'd3373259426;

    typedef struct packed {
        logic signed [CoordBits-1:0] a_x;
        logic signed [CoordBits-1:0] a_y;
        logic signed [CoordBits-1:0] b_x;
        logic signed [CoordBits-1:0] b_y;
    } t_in;

    typedef struct packed {
        logic [7:0] angle_deg;
        logic       angle_valid;
    } t_out;

    // control that travels beside the data through every stage
    typedef struct packed {
        logic vld;    // stage holds an item
        logic nz;     // both vectors have nonzero length
        logic dneg;   // dot product below zero
        logic dzero;  // dot product exactly zero
    } t_side;

    typedef logic [QBits-1:0] t_sq_tab [0:TabDepth-1];

    // cos(d deg)^2 in Q60 for d = 0..89, from an eleven-term series in Q30;
    // 45 degrees is exactly one half
    function automatic t_sq_tab sq_table();
        t_sq_tab         tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned sum;
        for (int d = 0; d < TabDepth; d++) begin
            x   = (64'(d) * PiQ30 + 64'd90) / 64'd180;
            x2  = (x * x + (64'd1 << 29)) >> 30;
            t   = 64'd1 << 30;
            sum = 64'd1 << 30;
            for (int k = 1; k <= 10; k++) begin
                t = ((t * x2 + (64'd1 << 29)) >> 30) / 64'((2 * k - 1) * (2 * k));
                if ((k % 2) == 1) begin
                    sum = sum - t;
                end else begin
                    sum = sum + t;
                end
            end
            tab[d] = QBits'(sum * sum);
        end
        tab[45] = QBits'(1) << 59;
        return tab;
    endfunction

    localparam t_sq_tab SqTab = sq_table();

    // magnitude of a two's complement component
    function automatic logic [CoordBits-1:0] mag(input logic signed [CoordBits-1:0] v);
        return v[CoordBits-1] ? CoordBits'(-v) : CoordBits'(v);
    endfunction

endpackage

[src/vad_sqmul.sv]
// two-stage split multipliers for |a|^2*|b|^2 and dot^2
module vad_sqmul
    import vad_pkg::*;
#(
    parameter int W = ProdBits
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  t_side          i_side,
    input  logic [W-1:0]   i_a2,
    input  logic [W-1:0]   i_b2,
    input  logic [W-1:0]   i_dm,
    output t_side          o_side,
    output logic [2*W-1:0] o_k,
    output logic [2*W-1:0] o_d2
);
    localparam int H = W / 2;

    logic [2*H-1:0] r_k_ll, r_k_lh, r_k_hl, r_k_hh;
    logic [2*H-1:0] r_d_ll, r_d_lh, r_d_hh;
    t_side          r_side1;
    logic [2*H:0]   k_mid;
    logic [2*H:0]   d_mid;

    // partial products of the half words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1.vld <= 1'b0;
        end else if (i_en) begin
            r_side1 <= i_side;
            r_k_ll  <= (2*H)'(i_a2[H-1:0]) * (2*H)'(i_b2[H-1:0]);
            r_k_lh  <= (2*H)'(i_a2[H-1:0]) * (2*H)'(i_b2[W-1:H]);
            r_k_hl  <= (2*H)'(i_a2[W-1:H]) * (2*H)'(i_b2[H-1:0]);
            r_k_hh  <= (2*H)'(i_a2[W-1:H]) * (2*H)'(i_b2[W-1:H]);
            r_d_ll  <= (2*H)'(i_dm[H-1:0]) * (2*H)'(i_dm[H-1:0]);
            r_d_lh  <= (2*H)'(i_dm[H-1:0]) * (2*H)'(i_dm[W-1:H]);
            r_d_hh  <= (2*H)'(i_dm[W-1:H]) * (2*H)'(i_dm[W-1:H]);
        end
    end

    assign k_mid = {1'b0, r_k_lh} + {1'b0, r_k_hl};
    assign d_mid = {r_d_lh, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_side.vld <= 1'b0;
        end else if (i_en) begin
            o_side <= r_side1;
            o_k    <= {r_k_hh, r_k_ll} + ((2*W)'(k_mid) << H);
            o_d2   <= {r_d_hh, r_d_ll} + ((2*W)'(d_mid) << H);
        end
    end

endmodule

[src/vad_div.sv]
// pipelined restoring divider, one quotient bit per stage
module vad_div
    import vad_pkg::*;
#(
    parameter int KW = WideBits,
    parameter int QW = QBits
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_side         i_side,
    input  logic [KW-1:0] i_d2,
    input  logic [KW-1:0] i_k,
    output t_side         o_side,
    output logic [QW-1:0] o_q,
    output logic          o_rz
);
    logic [KW-1:0] r_rem  [0:QW-1];
    logic [KW-1:0] r_k    [0:QW-1];
    logic [QW-1:0] r_q    [0:QW-1];
    t_side         r_side [0:QW-1];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [KW:0]   n_in;
        logic [KW-1:0] k_in;
        logic [QW-1:0] q_in;
        t_side         side_in;
        logic          ge;
        logic [KW:0]   n_rem;

        if (i == 0) begin : g_first
            // dot^2 never exceeds the length product, so no shift on the top bit
            assign n_in    = {1'b0, i_d2};
            assign k_in    = i_k;
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign n_in    = {r_rem[i-1], 1'b0};
            assign k_in    = r_k[i-1];
            assign q_in    = r_q[i-1];
            assign side_in = r_side[i-1];
        end

        assign ge    = n_in >= {1'b0, k_in};
        assign n_rem = ge ? (n_in - {1'b0, k_in}) : n_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[i].vld <= 1'b0;
            end else if (i_en) begin
                r_side[i] <= side_in;
                r_k[i]    <= k_in;
                r_rem[i]  <= n_rem[KW-1:0];
                r_q[i]    <= {q_in[QW-2:0], ge};
            end
        end
    end

    assign o_side = r_side[QW-1];
    assign o_q    = r_q[QW-1];
    assign o_rz   = r_rem[QW-1] == '0;

endmodule

[src/vad_srch.sv]
// pipelined binary search of the degree count against the cosine-squared table
module vad_srch
    import vad_pkg::*;
#(
    parameter int QW = QBits,
    parameter int NB = SrchSteps
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_side         i_side,
    input  logic [QW-1:0] i_q,
    input  logic          i_rz,
    output logic          o_vld,
    output t_out          o_res
);
    logic [NB-1:0] r_n    [0:NB-1];
    logic [QW-1:0] r_q    [0:NB-1];
    logic          r_rz   [0:NB-1];
    t_side         r_side [0:NB-1];
    logic [7:0]    n_last;

    for (genvar s = 0; s < NB; s++) begin : g_step
        logic [NB-1:0] n_in;
        logic [QW-1:0] q_in;
        logic          rz_in;
        t_side         side_in;
        logic [NB-1:0] cand;
        logic [NB-1:0] limit;
        logic          ok;
        logic [NB-1:0] idx;
        logic [QW-1:0] sq;
        logic          hit;

        if (s == 0) begin : g_first
            assign n_in    = '0;
            assign q_in    = i_q;
            assign rz_in   = i_rz;
            assign side_in = i_side;
        end else begin : g_next
            assign n_in    = r_n[s-1];
            assign q_in    = r_q[s-1];
            assign rz_in   = r_rz[s-1];
            assign side_in = r_side[s-1];
        end

        assign cand  = n_in | (NB'(1) << (NB - 1 - s));
        assign limit = side_in.dneg ? CountNeg : CountPos;
        assign ok    = cand <= limit;

        always_comb begin
            if (!ok) begin
                idx = '0;
            end else if (side_in.dneg) begin
                idx = CountNeg - cand;
            end else begin
                idx = cand;
            end
        end

        assign sq = SqTab[idx];
        // acute: ceil(q) at most cos^2; obtuse: floor(q) at least cos^2
        assign hit = side_in.dneg ? (q_in >= sq)
                                  : ((q_in < sq) || ((q_in == sq) && rz_in));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s].vld <= 1'b0;
            end else if (i_en) begin
                r_side[s] <= side_in;
                r_q[s]    <= q_in;
                r_rz[s]   <= rz_in;
                r_n[s]    <= (ok && hit) ? cand : n_in;
            end
        end
    end

    always_comb begin
        if (!r_side[NB-1].nz) begin
            n_last = '0;
        end else if (r_side[NB-1].dzero) begin
            n_last = AngleRight;
        end else if (r_side[NB-1].dneg) begin
            n_last = AngleRight + 8'(r_n[NB-1]);
        end else begin
            n_last = 8'(r_n[NB-1]);
        end
    end

    assign o_vld             = r_side[NB-1].vld;
    assign o_res.angle_deg   = n_last;
    assign o_res.angle_valid = r_side[NB-1].nz;

endmodule

[src/vector_angle_2d_degrees.sv]
// path: front stages, multiplier stages, divider, search, then the output register to o_data
// throughput: one transfer per cycle while o_stall is low; the 61-stage divider and the
// 7-stage search each take one step per stage, so every stage holds its own item
// stall: o_stall is a registered flag, high only while the output skid entry is occupied
// reset: synchronous active-low i_rst_n clears all valid bits and the skid, no clearing pass
module vector_angle_2d_degrees
    import vad_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    // whole pipeline moves when the skid entry is free
    logic en;

    // front stage 1: magnitudes and the six products
    logic [CoordBits-1:0] m_ax, m_ay, m_bx, m_by;
    logic                 r_f1_v;
    logic [ProdBits-1:0]  r_pax2, r_pay2, r_pbx2, r_pby2, r_pxx, r_pyy;
    logic                 r_nx, r_ny, r_az, r_bz;

    // front stage 2: squared lengths and dot product as sign and magnitude
    logic [ProdBits-1:0]  n_a2, n_b2, n_dm;
    logic                 n_dneg;
    t_side                n_side2;
    t_side                r_side2;
    logic [ProdBits-1:0]  r_a2, r_b2, r_dm;

    t_side                mul_side;
    logic [WideBits-1:0]  mul_k, mul_d2;
    t_side                div_side;
    logic [QBits-1:0]     div_q;
    logic                 div_rz;
    logic                 p_vld;
    t_out                 p_res;

    // output register and skid entry
    logic                 r_ov, r_sv;
    t_out                 r_od, r_sd;

    assign en      = !r_sv;
    assign o_stall = r_sv;

    assign m_ax = mag(i_data.a_x);
    assign m_ay = mag(i_data.a_y);
    assign m_bx = mag(i_data.b_x);
    assign m_by = mag(i_data.b_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (en) begin
            r_f1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pax2 <= ProdBits'(m_ax) * ProdBits'(m_ax);
            r_pay2 <= ProdBits'(m_ay) * ProdBits'(m_ay);
            r_pbx2 <= ProdBits'(m_bx) * ProdBits'(m_bx);
            r_pby2 <= ProdBits'(m_by) * ProdBits'(m_by);
            r_pxx  <= ProdBits'(m_ax) * ProdBits'(m_bx);
            r_pyy  <= ProdBits'(m_ay) * ProdBits'(m_by);
            r_nx   <= i_data.a_x[CoordBits-1] ^ i_data.b_x[CoordBits-1];
            r_ny   <= i_data.a_y[CoordBits-1] ^ i_data.b_y[CoordBits-1];
            r_az   <= (i_data.a_x == '0) && (i_data.a_y == '0);
            r_bz   <= (i_data.b_x == '0) && (i_data.b_y == '0);
        end
    end

    // each square is at most a quarter of the range, so the sums cannot carry out
    assign n_a2 = r_pax2 + r_pay2;
    assign n_b2 = r_pbx2 + r_pby2;

    always_comb begin
        if (r_nx == r_ny) begin
            n_dm   = r_pxx + r_pyy;
            n_dneg = r_nx;
        end else if (r_pxx >= r_pyy) begin
            n_dm   = r_pxx - r_pyy;
            n_dneg = r_nx;
        end else begin
            n_dm   = r_pyy - r_pxx;
            n_dneg = r_ny;
        end
    end

    always_comb begin
        n_side2.vld   = r_f1_v;
        n_side2.nz    = !r_az && !r_bz;
        n_side2.dzero = n_dm == '0;
        n_side2.dneg  = n_dneg && (n_dm != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side2.vld <= 1'b0;
        end else if (en) begin
            r_side2 <= n_side2;
            r_a2    <= n_a2;
            r_b2    <= n_b2;
            r_dm    <= n_dm;
        end
    end

    vad_sqmul #(
        .W(ProdBits)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_side (r_side2),
        .i_a2   (r_a2),
        .i_b2   (r_b2),
        .i_dm   (r_dm),
        .o_side (mul_side),
        .o_k    (mul_k),
        .o_d2   (mul_d2)
    );

    // cos^2 ratio as a Q60 quotient with a remainder-zero flag
    vad_div #(
        .KW(WideBits),
        .QW(QBits)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_side (mul_side),
        .i_d2   (mul_d2),
        .i_k    (mul_k),
        .o_side (div_side),
        .o_q    (div_q),
        .o_rz   (div_rz)
    );

    vad_srch #(
        .QW(QBits),
        .NB(SrchSteps)
    ) u_srch (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_side (div_side),
        .i_q    (div_q),
        .i_rz   (div_rz),
        .o_vld  (p_vld),
        .o_res  (p_res)
    );

    // output register with one skid entry; a result that meets a stalled
    // output parks in the skid and the pipeline holds on the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || !i_stall) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= p_vld;
            end
        end else if (p_vld && !r_sv) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || !i_stall) begin
            r_od <= r_sv ? r_sd : p_res;
        end else if (!r_sv) begin
            r_sd <= p_res;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

    // skid is only used while the output register is full
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid entry held while output register empty");

    // a result that meets a stalled full output goes to the skid
    a_skid_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall && p_vld && !r_sv) |=> (r_sv && r_ov))
        else $error("result dropped at stalled output");

    // zero-length vector gives angle zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_od.angle_valid) |-> (r_od.angle_deg == '0))
        else $error("nonzero angle on invalid result");

    // angle stays within a half turn
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_od.angle_deg <= 8'd180))
        else $error("angle above 180 degrees");

endmodule
